// ===== src/lcp_pkg.sv =====
// ----------------------------------------------------------------------------
// Line command parser package
// Shared types and constants: input item, result item, command codes and
// the command prefixes that the parser compares against.
// ----------------------------------------------------------------------------
package lcp_pkg;

	// Command codes carried with each result
	typedef enum logic [2:0] {
		CMD_NONE    = 3'd0,
		CMD_PING    = 3'd1,
		CMD_WRITE   = 3'd2,
		CMD_VERIFY  = 3'd3,
		CMD_UNKNOWN = 3'd4
	} cmd_code_t;

	// One input item: an abort flag or a received byte
	typedef struct packed {
		logic       abort;
		logic [7:0] data;
	} item_t;

	// One result item
	typedef struct packed {
		cmd_code_t   command;
		logic [31:0] size_value;
	} result_t;

	// Character codes
	localparam logic [7:0] CHR_CR    = 8'h0d;
	localparam logic [7:0] CHR_LF    = 8'h0a;
	localparam logic [7:0] CHR_TAB   = 8'h09;
	localparam logic [7:0] CHR_SPACE = 8'h20;
	localparam logic [7:0] CHR_ZERO  = 8'h30;
	localparam logic [7:0] CHR_NINE  = 8'h39;
	localparam logic [7:0] CHR_UC_A  = 8'h41;
	localparam logic [7:0] CHR_UC_Z  = 8'h5a;

	// Prefix lengths
	localparam int PING_LEN   = 4;
	localparam int WRITE_LEN  = 6;
	localparam int VERIFY_LEN = 6;

	// Lower-case prefix characters, first character at index zero
	localparam logic [7:0] PING_PFX [PING_LEN] = '{8'h70, 8'h69, 8'h6e, 8'h67};
	localparam logic [7:0] WRITE_PFX [WRITE_LEN] =
		'{8'h77, 8'h72, 8'h69, 8'h74, 8'h65, 8'h3a};
	localparam logic [7:0] VERIFY_PFX [VERIFY_LEN] =
		'{8'h76, 8'h65, 8'h72, 8'h69, 8'h66, 8'h79};

	// Fold A-Z to lower case, leave every other byte as it is
	function automatic logic [7:0] fold_case(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b >= CHR_UC_A && b <= CHR_UC_Z) begin
			r = b | 8'h20;
		end
		return r;
	endfunction

endpackage

// ===== src/lcp_parse_core.sv =====
// ----------------------------------------------------------------------------
// Line command parser core
// Holds the per-line state and works out the result of one item from the
// staged item and the current state in a single pass.
// ----------------------------------------------------------------------------
module lcp_parse_core #(
	parameter int LINE_MAX = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,   // staged item is consumed this cycle
	input  lcp_pkg::item_t   item,
	output lcp_pkg::result_t res
);
	import lcp_pkg::*;

	localparam int KW = $clog2(LINE_MAX);
	localparam logic [KW-1:0] KEEP_LIMIT = KW'(LINE_MAX - 1);

	// Line state
	logic          in_line_q;
	logic [KW-1:0] kept_q;
	logic          ping_q;
	logic          write_q;
	logic          verify_q;
	logic          digits_q;
	logic [31:0]   accum_q;

	logic          in_line_d;
	logic [KW-1:0] kept_d;
	logic          ping_d;
	logic          write_d;
	logic          verify_d;
	logic          digits_d;
	logic [31:0]   accum_d;

	logic       is_space;
	logic [7:0] folded;
	logic       is_digit;
	logic [31:0] accum_x10;

	assign is_space  = (item.data == CHR_CR) || (item.data == CHR_LF) ||
		(item.data == CHR_SPACE) || (item.data == CHR_TAB);
	assign folded    = fold_case(item.data);
	assign is_digit  = (item.data >= CHR_ZERO) && (item.data <= CHR_NINE);
	assign accum_x10 = {accum_q[28:0], 3'b000} + {accum_q[30:0], 1'b0};

	// Next state and result for the staged item
	always_comb begin
		in_line_d = in_line_q;
		kept_d    = kept_q;
		ping_d    = ping_q;
		write_d   = write_q;
		verify_d  = verify_q;
		digits_d  = digits_q;
		accum_d   = accum_q;
		res.command    = CMD_NONE;
		res.size_value = '0;
		if (item.abort) begin
			in_line_d = 1'b0;
			kept_d    = '0;
			ping_d    = 1'b1;
			write_d   = 1'b1;
			verify_d  = 1'b1;
			digits_d  = 1'b1;
			accum_d   = '0;
		end else if (!in_line_q && is_space) begin
			// Blank bytes between lines are skipped
		end else if (item.data == CHR_CR) begin
			// Carriage return inside a line is ignored
		end else if (item.data == CHR_LF) begin
			// End of line: the flags select the command
			in_line_d = 1'b0;
			if (kept_q != '0) begin
				if (ping_q && kept_q >= KW'(PING_LEN)) begin
					res.command = CMD_PING;
				end else if (write_q && kept_q >= KW'(WRITE_LEN)) begin
					res.command    = CMD_WRITE;
					res.size_value = accum_q;
				end else if (verify_q && kept_q >= KW'(VERIFY_LEN)) begin
					res.command = CMD_VERIFY;
				end else begin
					res.command = CMD_UNKNOWN;
				end
			end
		end else if (!in_line_q) begin
			// First byte of a new line: it is the byte at position zero
			in_line_d = 1'b1;
			kept_d    = KW'(1);
			ping_d    = (folded == PING_PFX[0]);
			write_d   = (folded == WRITE_PFX[0]);
			verify_d  = (folded == VERIFY_PFX[0]);
			digits_d  = 1'b1;
			accum_d   = '0;
		end else if (kept_q < KEEP_LIMIT) begin
			// Kept byte inside the line
			kept_d = kept_q + KW'(1);
			if (kept_q < KW'(PING_LEN) && folded != PING_PFX[kept_q[1:0]]) begin
				ping_d = 1'b0;
			end
			if (kept_q < KW'(WRITE_LEN)) begin
				if (folded != WRITE_PFX[kept_q[2:0]]) begin
					write_d = 1'b0;
				end
				if (folded != VERIFY_PFX[kept_q[2:0]]) begin
					verify_d = 1'b0;
				end
			end else if (digits_q) begin
				if (is_digit) begin
					accum_d = accum_x10 + {28'd0, item.data[3:0]};
				end else begin
					digits_d = 1'b0;
				end
			end
		end
	end

	// State registers, updated once per consumed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_line_q <= 1'b0;
			kept_q    <= '0;
			ping_q    <= 1'b1;
			write_q   <= 1'b1;
			verify_q  <= 1'b1;
			digits_q  <= 1'b1;
			accum_q   <= '0;
		end else if (fire) begin
			in_line_q <= in_line_d;
			kept_q    <= kept_d;
			ping_q    <= ping_d;
			write_q   <= write_d;
			verify_q  <= verify_d;
			digits_q  <= digits_d;
			accum_q   <= accum_d;
		end
	end

endmodule

// ===== src/line_command_parser.sv =====
// ----------------------------------------------------------------------------
// Line command parser
// Parses serial text lines into ping, write, verify and unknown commands.
//
//   Channel | Dir | tdata            | tuser
//   s_      | in  | [7:0] rx_byte    | [0] cmd (1 = abort line)
//   m_      | out | [31:0] size_value| [2:0] command
//
// Every accepted item gives exactly one result, through the input register and
// the result register; one item is accepted per cycle when the output is taken.
// The rate is set by the single pass through the parse core between the
// input register and the result register.
// Reset clears both stages and returns the line state to idle.
// A stalled output holds its result; the input register keeps taking items
// as long as the result register can move on.
// ----------------------------------------------------------------------------
module line_command_parser #(
	parameter int LINE_MAX = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [0:0]  s_tuser,   // [0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] size_value
	output logic [2:0]  m_tuser    // [2:0] command
);
	import lcp_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t res_s2;
	result_t res_comb;
	logic    advance;
	logic    fire;

	// The result register moves on when it is empty or being taken
	assign advance  = !valid_s2 || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.abort <= s_tuser[0];
			item_s1.data  <= s_tdata;
		end
	end

	lcp_parse_core #(
		.LINE_MAX(LINE_MAX)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.item  (item_s1),
		.res   (res_comb)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_comb;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = res_s2.size_value;
	assign m_tuser  = res_s2.command;

`ifndef ASSERT_OFF
	// A consumed item always reaches the result register
	a_fire_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> m_tvalid)
		else $error("consumed item produced no result");

	// Only a write result carries a number
	a_size_only_write: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != CMD_WRITE) |-> (m_tdata == 32'd0))
		else $error("non-write result carries a number");

	// An abort always answers with no command
	a_abort_none: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.abort) |=> (m_tuser == CMD_NONE))
		else $error("abort gave a command");
`endif

endmodule
